>>> sv/hevc_sps_field_parser_unit_macros.svh
// Assertion macros shared by the checker of the SPS field parser.
// Each macro expects signals named clk and rst_n in the enclosing scope.
`ifndef HEVC_SPS_FIELD_PARSER_UNIT_MACROS_SVH
`define HEVC_SPS_FIELD_PARSER_UNIT_MACROS_SVH

// Implication in the same cycle.
`define HSFP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hsfp assertion failed");

// Implication in the next cycle.
`define HSFP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hsfp assertion failed");

`endif

>>> sv/hsfp_pkg.sv
// Package of the SPS field parser: parse phases, status codes, queue entry
// and result types. No dependencies.
package hsfp_pkg;

  localparam int unsigned DefQueueDepth = 2;

  localparam logic [6:0] SUB_PROFILE_BITS = 7'd88;
  localparam logic [5:0] GOLOMB_MAX_ZEROS = 6'd31;
  localparam logic [47:0] CHROMA_MAX = 48'd3;
  localparam logic [47:0] DEPTH_MAX = 48'd7;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NO_DATA   = 3'd1;
  localparam logic [2:0] ST_TRUNC     = 3'd2;
  localparam logic [2:0] ST_PREFIX    = 3'd3;
  localparam logic [2:0] ST_CHROMA    = 3'd4;
  localparam logic [2:0] ST_LUMA_BD   = 3'd5;
  localparam logic [2:0] ST_CHROMA_BD = 3'd6;

  typedef enum logic [4:0] {
    PH_VPS, PH_SUBL, PH_NEST, PH_SPACE, PH_TIER, PH_IDC, PH_COMPAT, PH_CONSTR,
    PH_LEVEL, PH_SUBFLAG, PH_ALIGN, PH_SUBPROF, PH_SUBLEV, PH_SPSID, PH_CHROMA,
    PH_SEPCOL, PH_WIDTH, PH_HEIGHT, PH_CONFFLAG, PH_CONF, PH_LUMA, PH_CDEPTH,
    PH_DONE
  } phase_t;

  // One byte handed from the front to the back.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       payload;  // byte carries parse bits
  } q_entry_t;

  // Result, packed from the highest field down so status sits in the low bits.
  typedef struct packed {
    logic        pad;
    logic [2:0]  chroma_depth_minus8;
    logic [2:0]  luma_depth_minus8;
    logic [1:0]  chroma_format;
    logic        temporal_nesting;
    logic [2:0]  sub_layers_minus1;
    logic [7:0]  level_idc;
    logic [47:0] constraint_flags;
    logic [31:0] compatibility_flags;
    logic [4:0]  profile_idc;
    logic        tier_flag;
    logic [1:0]  profile_space;
    logic [2:0]  status;
  } result_t;

endpackage

>>> sv/hevc_sps_field_parser_unit.sv
// Channel  | Ports          | Contents
// ---------+----------------+-----------------------------------------------
// input    | in_t*          | one raw SPS NAL byte per request, tlast = last
// result   | out_t*         | one status and field set per NAL unit
//
// A payload byte is walked bit by bit through the back end, and each empty
// field it steps over (skipped sub-layer entries, alignment) adds a step.
// Header, emulation-prevention and post-parse bytes are popped without a walk.
// Reset is synchronous and active low and clears all control state.
// The front keeps accepting bytes into the queue while a result waits to be
// taken; the back stops only when a new result meets a full output register.
//
// Top level of the SPS field parser; depends on hsfp_pkg, hsfp_front,
// hsfp_queue and hsfp_back.
module hevc_sps_field_parser_unit
  import hsfp_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = DefQueueDepth
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // nal_byte
  input  logic         in_tlast,   // last_byte
  output logic         out_tvalid,
  input  logic         out_tready,
  // status, profile_space, tier_flag, profile_idc, compatibility_flags,
  // constraint_flags, level_idc, sub_layers_minus1, temporal_nesting,
  // chroma_format, luma_depth_minus8, chroma_depth_minus8, zero pad
  output logic [111:0] out_tdata
);

  logic     q_full, q_push, q_pop, q_head_valid;
  q_entry_t q_in, q_head;
  result_t  res;

  // Header and emulation-prevention marking.
  hsfp_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_data  (in_tdata),
    .in_last  (in_tlast),
    .q_full   (q_full),
    .in_ready (in_tready),
    .q_push   (q_push),
    .q_entry  (q_in)
  );

  // Decouples byte intake from the bit-serial walk.
  hsfp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_in),
    .pop        (q_pop),
    .full       (q_full),
    .head_valid (q_head_valid),
    .head       (q_head)
  );

  // Field walker and result register.
  hsfp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_head_valid),
    .head       (q_head),
    .pop        (q_pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_res    (res)
  );

  assign out_tdata = res;

endmodule

>>> sv/hsfp_front.sv
// Front end of the SPS field parser: marks the NAL header bytes and the
// emulation-prevention bytes as carrying no parse bits. Depends on hsfp_pkg.
module hsfp_front
  import hsfp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [7:0] in_data,
  input  logic       in_last,
  input  logic       q_full,
  output logic       in_ready,
  output logic       q_push,
  output q_entry_t   q_entry
);

  logic [1:0] hdr_r, hdr_nxt;
  logic [1:0] zrun_r, zrun_nxt;
  logic       take;

  assign in_ready = !q_full;
  assign take     = in_valid && !q_full;
  assign q_push   = take;

  always_comb begin
    hdr_nxt          = hdr_r;
    zrun_nxt         = zrun_r;
    q_entry.data     = in_data;
    q_entry.last     = in_last;
    q_entry.payload  = 1'b0;
    if (hdr_r != 2'd2) begin
      hdr_nxt = hdr_r + 2'd1;
    end else if (zrun_r >= 2'd2 && in_data == 8'h03) begin
      zrun_nxt = 2'd0;
    end else begin
      q_entry.payload = 1'b1;
      if (in_data == 8'h00) begin
        zrun_nxt = (zrun_r == 2'd3) ? 2'd3 : zrun_r + 2'd1;
      end else begin
        zrun_nxt = 2'd0;
      end
    end
    if (in_last) begin
      hdr_nxt  = 2'd0;
      zrun_nxt = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_r  <= 2'd0;
      zrun_r <= 2'd0;
    end else if (take) begin
      hdr_r  <= hdr_nxt;
      zrun_r <= zrun_nxt;
    end
  end

endmodule

>>> sv/hsfp_queue.sv
// Short queue between the front and the back of the SPS field parser.
// Depends on hsfp_pkg.
module hsfp_queue
  import hsfp_pkg::*;
#(
  parameter int unsigned DEPTH = DefQueueDepth
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  q_entry_t push_entry,
  input  logic     pop,
  output logic     full,
  output logic     head_valid,
  output q_entry_t head
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  q_entry_t        mem_r [DEPTH];
  logic [PW-1:0]   wp_r, rp_r;
  logic [CW-1:0]   cnt_r;

  assign full       = (cnt_r == CW'(DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head       = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + PW'(1);
      end
      if (pop) begin
        rp_r <= (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + PW'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

endmodule

>>> sv/hsfp_back.sv
// Back end of the SPS field parser: bit-serial field walker and the result
// register. Depends on hsfp_pkg.
module hsfp_back
  import hsfp_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     head_valid,
  input  q_entry_t head,
  output logic     pop,
  output logic     out_valid,
  input  logic     out_ready,
  output result_t  out_res
);

  phase_t      phase_r, phase_nxt, ph_n;
  logic [6:0]  bd_r, bd_nxt;
  logic [47:0] acc_r, acc_nxt, fin_v;
  logic [5:0]  zc_r, zc_nxt;
  logic        sfx_r, sfx_nxt;
  logic [13:0] flags_r, flags_nxt;
  logic [2:0]  li_r, li_nxt;
  logic [1:0]  space_r, space_nxt;
  logic        tier_r, tier_nxt;
  logic [4:0]  idc_r, idc_nxt;
  logic [31:0] compat_r, compat_nxt;
  logic [47:0] constr_r, constr_nxt;
  logic [7:0]  level_r, level_nxt;
  logic [2:0]  subl_r, subl_nxt;
  logic        nest_r, nest_nxt;
  logic [1:0]  chroma_r, chroma_nxt;
  logic [2:0]  luma_r, luma_nxt;
  logic [2:0]  cdepth_r, cdepth_nxt;
  logic [2:0]  err_r, err_nxt;
  logic        done_r, done_nxt;
  logic        had_r, had_nxt;
  logic [2:0]  bit_r, bit_nxt;
  logic        ov_r, ov_nxt;
  result_t     res_r, res_nxt;

  logic        is_gol, zero_len, active, skip, consume, byte_done, stall, en, fin, bit_in;
  logic [6:0]  flen;
  logic [2:0]  diff;
  logic [2:0]  status;

  assign out_valid = ov_r;
  assign out_res   = res_r;

  // Field kind and length of the current phase.
  always_comb begin
    is_gol = 1'b0;
    flen   = 7'd0;
    diff   = subl_r - 3'd1 - li_r;
    unique case (phase_r) inside
      PH_SPSID, PH_CHROMA, PH_WIDTH, PH_HEIGHT, PH_CONF, PH_LUMA, PH_CDEPTH: is_gol = 1'b1;
      PH_VPS:      flen = 7'd4;
      PH_SUBL:     flen = 7'd3;
      PH_NEST, PH_TIER, PH_CONFFLAG: flen = 7'd1;
      PH_SPACE:    flen = 7'd2;
      PH_IDC:      flen = 7'd5;
      PH_COMPAT:   flen = 7'd32;
      PH_CONSTR:   flen = 7'd48;
      PH_LEVEL:    flen = 7'd8;
      PH_SUBFLAG:  flen = {3'd0, subl_r, 1'b0};
      PH_ALIGN:    flen = (subl_r != 3'd0) ? {2'd0, 4'd8 - {1'b0, subl_r}, 1'b0} : 7'd0;
      PH_SUBPROF:  flen = flags_r[{diff, 1'b1}] ? SUB_PROFILE_BITS : 7'd0;
      PH_SUBLEV:   flen = flags_r[{diff, 1'b0}] ? 7'd8 : 7'd0;
      PH_SEPCOL:   flen = (chroma_r == 2'd3) ? 7'd1 : 7'd0;
      default:     flen = 7'd0;
    endcase
  end

  assign zero_len  = !is_gol && flen == 7'd0 && phase_r != PH_DONE;
  assign active    = head_valid && head.payload && !done_r;
  assign skip      = active && zero_len;
  assign consume   = active && !zero_len;
  assign bit_in    = head.data[3'd7 - bit_r];
  assign byte_done = head_valid && (!head.payload || done_r || (consume && bit_r == 3'd7));
  assign stall     = byte_done && head.last && ov_r && !out_ready;
  assign en        = head_valid && !stall;
  assign pop       = en && byte_done;

  always_comb begin
    phase_nxt = phase_r; bd_nxt = bd_r; acc_nxt = acc_r; zc_nxt = zc_r;
    sfx_nxt = sfx_r; flags_nxt = flags_r; li_nxt = li_r; space_nxt = space_r;
    tier_nxt = tier_r; idc_nxt = idc_r; compat_nxt = compat_r; constr_nxt = constr_r;
    level_nxt = level_r; subl_nxt = subl_r; nest_nxt = nest_r; chroma_nxt = chroma_r;
    luma_nxt = luma_r; cdepth_nxt = cdepth_r; err_nxt = err_r; done_nxt = done_r;
    had_nxt = had_r; bit_nxt = bit_r; ov_nxt = ov_r; res_nxt = res_r;
    fin = 1'b0; fin_v = '0; ph_n = phase_r; status = ST_OK;

    if (en && head.payload) begin
      had_nxt = 1'b1;
    end
    if (en && skip) begin
      fin = 1'b1;
    end
    if (en && consume) begin
      bit_nxt = bit_r + 3'd1;
      if (is_gol && !sfx_r) begin
        if (!bit_in) begin
          zc_nxt = zc_r + 6'd1;
          if (zc_r == GOLOMB_MAX_ZEROS) begin
            err_nxt   = ST_PREFIX;
            done_nxt  = 1'b1;
            phase_nxt = PH_DONE;
          end
        end else begin
          sfx_nxt = 1'b1;
          acc_nxt = 48'd1;
          fin     = (zc_r == 6'd0);
        end
      end else begin
        acc_nxt = {acc_r[46:0], bit_in};
        bd_nxt  = bd_r + 7'd1;
        if (is_gol) begin
          fin   = (bd_nxt >= {1'b0, zc_r});
          fin_v = acc_nxt - 48'd1;
        end else begin
          fin   = (bd_nxt >= flen);
          fin_v = acc_nxt;
        end
      end
    end

    // Field completion: store the value and choose the next phase.
    if (fin) begin
      ph_n = phase_t'(phase_r + 5'd1);
      case (phase_r)
        PH_SUBL:    subl_nxt   = fin_v[2:0];
        PH_NEST:    nest_nxt   = fin_v[0];
        PH_SPACE:   space_nxt  = fin_v[1:0];
        PH_TIER:    tier_nxt   = fin_v[0];
        PH_IDC:     idc_nxt    = fin_v[4:0];
        PH_COMPAT:  compat_nxt = fin_v[31:0];
        PH_CONSTR:  constr_nxt = fin_v;
        PH_LEVEL:   level_nxt  = fin_v[7:0];
        PH_SUBFLAG: flags_nxt  = fin_v[13:0];
        PH_ALIGN: begin
          li_nxt = 3'd0;
          ph_n   = (subl_r != 3'd0) ? PH_SUBPROF : PH_SPSID;
        end
        PH_SUBLEV: begin
          li_nxt = li_r + 3'd1;
          ph_n   = (li_nxt < subl_r) ? PH_SUBPROF : PH_SPSID;
        end
        PH_CHROMA: begin
          if (fin_v > CHROMA_MAX) begin
            err_nxt = ST_CHROMA; done_nxt = 1'b1; ph_n = PH_DONE;
          end else begin
            chroma_nxt = fin_v[1:0];
          end
        end
        PH_CONFFLAG: begin
          li_nxt = 3'd0;
          ph_n   = fin_v[0] ? PH_CONF : PH_LUMA;
        end
        PH_CONF: begin
          li_nxt = li_r + 3'd1;
          ph_n   = (li_nxt < 3'd4) ? PH_CONF : PH_LUMA;
        end
        PH_LUMA: begin
          if (fin_v > DEPTH_MAX) begin
            err_nxt = ST_LUMA_BD; done_nxt = 1'b1; ph_n = PH_DONE;
          end else begin
            luma_nxt = fin_v[2:0];
          end
        end
        PH_CDEPTH: begin
          if (fin_v > DEPTH_MAX) begin
            err_nxt = ST_CHROMA_BD;
          end else begin
            cdepth_nxt = fin_v[2:0];
          end
          done_nxt = 1'b1;
          ph_n     = PH_DONE;
        end
        default: ;
      endcase
      phase_nxt = ph_n;
      bd_nxt    = 7'd0;
      acc_nxt   = '0;
      zc_nxt    = 6'd0;
      sfx_nxt   = 1'b0;
    end

    if (pop) begin
      bit_nxt = 3'd0;
    end
    if (ov_r && out_ready) begin
      ov_nxt = 1'b0;
    end

    // End of the unit: load the result and start over.
    if (pop && head.last) begin
      if (done_nxt) begin
        status = err_nxt;
      end else if (!had_nxt) begin
        status = ST_NO_DATA;
      end else begin
        status = ST_TRUNC;
      end
      res_nxt        = '0;
      res_nxt.status = status;
      if (status == ST_OK) begin
        res_nxt.profile_space       = space_nxt;
        res_nxt.tier_flag           = tier_nxt;
        res_nxt.profile_idc         = idc_nxt;
        res_nxt.compatibility_flags = compat_nxt;
        res_nxt.constraint_flags    = constr_nxt;
        res_nxt.level_idc           = level_nxt;
        res_nxt.sub_layers_minus1   = subl_nxt;
        res_nxt.temporal_nesting    = nest_nxt;
        res_nxt.chroma_format       = chroma_nxt;
        res_nxt.luma_depth_minus8   = luma_nxt;
        res_nxt.chroma_depth_minus8 = cdepth_nxt;
      end
      ov_nxt = 1'b1;
      phase_nxt = PH_VPS; bd_nxt = 7'd0; acc_nxt = '0; zc_nxt = 6'd0; sfx_nxt = 1'b0;
      flags_nxt = '0; li_nxt = 3'd0; space_nxt = '0; tier_nxt = 1'b0; idc_nxt = '0;
      compat_nxt = '0; constr_nxt = '0; level_nxt = '0; subl_nxt = '0; nest_nxt = 1'b0;
      chroma_nxt = '0; luma_nxt = '0; cdepth_nxt = '0; err_nxt = ST_OK; done_nxt = 1'b0;
      had_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_VPS; bd_r <= 7'd0; acc_r <= '0; zc_r <= 6'd0; sfx_r <= 1'b0;
      flags_r <= '0; li_r <= 3'd0; space_r <= '0; tier_r <= 1'b0; idc_r <= '0;
      compat_r <= '0; constr_r <= '0; level_r <= '0; subl_r <= '0; nest_r <= 1'b0;
      chroma_r <= '0; luma_r <= '0; cdepth_r <= '0; err_r <= ST_OK; done_r <= 1'b0;
      had_r <= 1'b0; bit_r <= 3'd0; ov_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt; bd_r <= bd_nxt; acc_r <= acc_nxt; zc_r <= zc_nxt;
      sfx_r <= sfx_nxt; flags_r <= flags_nxt; li_r <= li_nxt; space_r <= space_nxt;
      tier_r <= tier_nxt; idc_r <= idc_nxt; compat_r <= compat_nxt;
      constr_r <= constr_nxt; level_r <= level_nxt; subl_r <= subl_nxt;
      nest_r <= nest_nxt; chroma_r <= chroma_nxt; luma_r <= luma_nxt;
      cdepth_r <= cdepth_nxt; err_r <= err_nxt; done_r <= done_nxt;
      had_r <= had_nxt; bit_r <= bit_nxt; ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

endmodule

>>> sv/hsfp_checker.sv
// Port-level checker for the SPS field parser, bound to the top level.
// Depends on hevc_sps_field_parser_unit_macros.svh.
`include "hevc_sps_field_parser_unit_macros.svh"

module hsfp_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [111:0] out_tdata
);

  `HSFP_ASSERT_IMP(a_status_range, out_tvalid, out_tdata[2:0] <= 3'd6 && !out_tdata[111])
  `HSFP_ASSERT_IMP(a_fail_zero, out_tvalid && out_tdata[2:0] != 3'd0, out_tdata[110:3] == '0)
  `HSFP_ASSERT_NXT(a_hold_valid, out_tvalid && !out_tready, out_tvalid)
  `HSFP_ASSERT_NXT(a_hold_data, out_tvalid && !out_tready, $stable(out_tdata))

endmodule

bind hevc_sps_field_parser_unit hsfp_checker u_hsfp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

>>> sim/tb_hevc_sps_field_parser_unit.sv
// Self-checking bench for hevc_sps_field_parser_unit: drives SPS NAL units
// byte by byte and checks every status/field result. Depends on hsfp_pkg.
`timescale 1ns / 1ps

module tb_hevc_sps_field_parser_unit
  import hsfp_pkg::*;
();

  // Bit-serial model of the SPS parser; one instance holds the unit state.
  class sps_field_scoreboard;
    int unsigned hdr_seen, zeros_seen;
    phase_t phase;
    int unsigned bits_done, gz;
    logic [63:0] acc;
    logic [13:0] sub_flags;
    logic [2:0] lidx;
    logic [1:0] space_v;
    logic tier_v, nest_v;
    logic [4:0] idc_v;
    logic [31:0] compat_v;
    logic [47:0] constr_v;
    logic [7:0] level_v;
    logic [2:0] subl_v, luma_v, cdep_v, err;
    logic [1:0] chroma_v;
    bit done;
    result_t pending[$];
    int errors;

    function new();
      errors = 0;
      clear();
    endfunction

    function void clear();
      hdr_seen = 0; zeros_seen = 0; sub_flags = 0; lidx = 0;
      space_v = 0; tier_v = 0; nest_v = 0; idc_v = 0; compat_v = 0; constr_v = 0;
      level_v = 0; subl_v = 0; luma_v = 0; cdep_v = 0; chroma_v = 0; err = ST_OK;
      done = 0;
      go_to(PH_VPS);
    endfunction

    function bit is_eg(phase_t p);
      return p inside {PH_SPSID, PH_CHROMA, PH_WIDTH, PH_HEIGHT, PH_CONF, PH_LUMA,
                       PH_CDEPTH};
    endfunction

    function int unsigned len_of(phase_t p);
      int unsigned m;
      m = subl_v;
      case (p)
        PH_VPS: return 4;
        PH_SUBL: return 3;
        PH_NEST, PH_TIER, PH_CONFFLAG: return 1;
        PH_SPACE: return 2;
        PH_IDC: return 5;
        PH_COMPAT: return 32;
        PH_CONSTR: return 48;
        PH_LEVEL: return 8;
        PH_SUBFLAG: return 2 * m;
        PH_ALIGN: return m > 0 ? (8 - m) * 2 : 0;
        PH_SUBPROF: return sub_flags[2 * (m - 1 - lidx) + 1] ? 88 : 0;
        PH_SUBLEV: return sub_flags[2 * (m - 1 - lidx)] ? 8 : 0;
        PH_SEPCOL: return chroma_v == 3 ? 1 : 0;
        default: return 0;
      endcase
    endfunction

    function void fail_with(logic [2:0] code);
      err = code;
      done = 1;
    endfunction

    // Stores a completed field and returns the phase that follows.
    function phase_t complete(phase_t p, logic [63:0] v);
      int unsigned m;
      m = subl_v;
      case (p)
        PH_SUBL: subl_v = v[2:0];
        PH_NEST: nest_v = v[0];
        PH_SPACE: space_v = v[1:0];
        PH_TIER: tier_v = v[0];
        PH_IDC: idc_v = v[4:0];
        PH_COMPAT: compat_v = v[31:0];
        PH_CONSTR: constr_v = v[47:0];
        PH_LEVEL: level_v = v[7:0];
        PH_SUBFLAG: sub_flags = v[13:0];
        PH_ALIGN: begin
          lidx = 0;
          return m > 0 ? PH_SUBPROF : PH_SPSID;
        end
        PH_SUBLEV: begin
          lidx = lidx + 1;
          return lidx < m ? PH_SUBPROF : PH_SPSID;
        end
        PH_CHROMA: begin
          if (v > 3) begin
            fail_with(ST_CHROMA);
            return PH_DONE;
          end
          chroma_v = v[1:0];
        end
        PH_CONFFLAG: begin
          lidx = 0;
          return v != 0 ? PH_CONF : PH_LUMA;
        end
        PH_CONF: begin
          lidx = lidx + 1;
          return lidx < 4 ? PH_CONF : PH_LUMA;
        end
        PH_LUMA: begin
          if (v > 7) begin
            fail_with(ST_LUMA_BD);
            return PH_DONE;
          end
          luma_v = v[2:0];
        end
        PH_CDEPTH: begin
          if (v > 7) begin
            fail_with(ST_CHROMA_BD);
            return PH_DONE;
          end
          cdep_v = v[2:0];
          done = 1;
          return PH_DONE;
        end
        default: ;
      endcase
      return phase_t'(p + 1);
    endfunction

    // Enters a phase, stepping over fields that carry no bits.
    function void go_to(phase_t p);
      forever begin
        phase = p; bits_done = 0; acc = 0; gz = 0;
        if (p == PH_DONE || is_eg(p) || len_of(p) != 0) return;
        p = complete(p, 0);
      end
    endfunction

    function void bit_in(bit b);
      phase_t p;
      p = phase;
      if (done || p == PH_DONE) return;
      if (is_eg(p)) begin
        if (acc == 0) begin
          if (!b) begin
            gz++;
            if (gz > 31) begin
              fail_with(ST_PREFIX);
              phase = PH_DONE;
            end
            return;
          end
          acc = 1;
        end else begin
          acc = {acc[62:0], b};
          bits_done++;
        end
        if (bits_done >= gz) go_to(complete(p, acc - 1));
        return;
      end
      acc = {acc[62:0], b};
      bits_done++;
      if (bits_done >= len_of(p)) go_to(complete(p, acc));
    endfunction

    function void note_request(logic [7:0] byte_v, logic last);
      result_t r;
      if (hdr_seen < 2) hdr_seen++;
      else if (zeros_seen >= 2 && byte_v == 8'h03) zeros_seen = 0;
      else begin
        for (int k = 7; k >= 0; k--) bit_in(byte_v[k]);
        zeros_seen = byte_v == 0 ? (zeros_seen < 3 ? zeros_seen + 1 : 3) : 0;
      end
      if (!last) return;
      r = '0;
      if (done) r.status = err;
      else if (phase == PH_VPS && bits_done == 0) r.status = ST_NO_DATA;
      else r.status = ST_TRUNC;
      if (r.status == ST_OK) begin
        r.profile_space = space_v; r.tier_flag = tier_v; r.profile_idc = idc_v;
        r.compatibility_flags = compat_v; r.constraint_flags = constr_v;
        r.level_idc = level_v; r.sub_layers_minus1 = subl_v; r.temporal_nesting = nest_v;
        r.chroma_format = chroma_v; r.luma_depth_minus8 = luma_v;
        r.chroma_depth_minus8 = cdep_v;
      end
      pending.insert(pending.size(), r);
      clear();
    endfunction

    function void check_result(logic [111:0] data);
      result_t got, want;
      got = result_t'(data);
      if (pending.size() == 0) begin
        report("result with nothing expected");
        return;
      end
      want = pending.pop_front();
      if (got.status != want.status) report("status");
      if (got.profile_space != want.profile_space) report("profile_space");
      if (got.tier_flag != want.tier_flag) report("tier_flag");
      if (got.profile_idc != want.profile_idc) report("profile_idc");
      if (got.compatibility_flags != want.compatibility_flags) report("compatibility_flags");
      if (got.constraint_flags != want.constraint_flags) report("constraint_flags");
      if (got.level_idc != want.level_idc) report("level_idc");
      if (got.sub_layers_minus1 != want.sub_layers_minus1) report("sub_layers_minus1");
      if (got.temporal_nesting != want.temporal_nesting) report("temporal_nesting");
      if (got.chroma_format != want.chroma_format) report("chroma_format");
      if (got.luma_depth_minus8 != want.luma_depth_minus8) report("luma_depth_minus8");
      if (got.chroma_depth_minus8 != want.chroma_depth_minus8)
        report("chroma_depth_minus8");
    endfunction

    function void report(string what);
      errors++;
      $display("mismatch at %0t: %s", $realtime, what);
    endfunction
  endclass

  localparam int unsigned CycleLimit = 2000000;

  logic clk, rst_n;
  logic in_tvalid, in_tready, in_tlast;
  logic [7:0] in_tdata;
  logic out_tvalid, out_tready;
  logic [111:0] out_tdata;

  sps_field_scoreboard sb;
  int unsigned cycles;
  int unsigned bytes_sent;
  // Idle percentage of each side; zero during the quiet stretch.
  int unsigned in_idle_pct, out_idle_pct;
  bit hold_results;

  hevc_sps_field_parser_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // The run ends at a generous cycle limit if results stop coming.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Results are checked at the rising edge; tready changes at the falling edge.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  always @(negedge clk) begin
    if (!rst_n || hold_results) out_tready <= 1'b0;
    else out_tready <= ($urandom_range(99) >= out_idle_pct);
  end

  // One NAL unit, byte by byte as an assembled payload.
  logic [7:0] unit_bytes[$];

  // Sends one byte request and notes it once it has been accepted. Valid is
  // left high so the next byte can follow at once; idling or a pause drops it.
  task automatic send_byte(logic [7:0] b, logic last);
    while ($urandom_range(99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    in_tlast <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_request(b, last);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_unit();
    foreach (unit_bytes[i]) send_byte(unit_bytes[i], i == unit_bytes.size() - 1);
  endtask

  // Bit writer used to build well-formed payloads.
  bit bitbuf[$];

  task automatic put_bits(logic [63:0] v, int n);
    for (int k = n - 1; k >= 0; k--) bitbuf.insert(bitbuf.size(), v[k]);
  endtask

  task automatic put_ue(logic [31:0] v);
    logic [32:0] x;
    int nb;
    x = {1'b0, v} + 1;
    nb = 0;
    for (int k = 0; k < 33; k++) if (x[k]) nb = k + 1;
    put_bits(0, nb - 1);
    put_bits(x, nb);
  endtask

  // Packs the bit buffer into bytes with emulation prevention and a header.
  task automatic pack_unit(int trim);
    logic [7:0] b;
    int zr;
    unit_bytes.delete();
    unit_bytes.insert(unit_bytes.size(), 8'($urandom_range(255)));
    unit_bytes.insert(unit_bytes.size(), 8'($urandom_range(255)));
    while (bitbuf.size() % 8 != 0) bitbuf.insert(bitbuf.size(), 1'($urandom_range(1)));
    zr = 0;
    for (int i = 0; i < bitbuf.size(); i += 8) begin
      for (int k = 0; k < 8; k++) b[7 - k] = bitbuf[i + k];
      if (zr >= 2 && b <= 8'h03) begin
        unit_bytes.insert(unit_bytes.size(), 8'h03);
        zr = 0;
      end
      unit_bytes.insert(unit_bytes.size(), b);
      zr = b == 0 ? zr + 1 : 0;
    end
    bitbuf.delete();
    repeat ($urandom_range(3))
      unit_bytes.insert(unit_bytes.size(), 8'($urandom_range(255)));
    while (trim > 0 && unit_bytes.size() > 1) begin
      void'(unit_bytes.pop_back());
      trim--;
    end
  endtask

  // Builds one SPS; mode 0 random legal, 1 extremes high, 2 zero but ids and sizes, 3 bad value.
  task automatic build_sps(int mode);
    int m;
    bit big;
    logic [13:0] fl;
    big = mode == 1;
    m = mode == 1 ? 7 : (mode == 2 ? 0 : $urandom_range(7));
    put_bits(mode == 1 ? 4'hf : $urandom_range(15), 4);
    put_bits(m, 3);
    put_bits(mode == 1 ? 1 : (mode == 2 ? 0 : $urandom_range(1)), 1);
    put_bits(mode == 1 ? 64'hff : (mode == 2 ? 0 : $urandom_range(255)), 8);
    put_bits(mode == 1 ? 64'hffffffff : (mode == 2 ? 0 : $urandom), 32);
    put_bits(mode == 1 ? 64'hffffffffffff : (mode == 2 ? 0 : {$urandom, $urandom}), 48);
    put_bits(mode == 1 ? 64'hff : (mode == 2 ? 0 : $urandom_range(255)), 8);
    fl = big ? 14'h3fff : (mode == 2 ? 0 : $urandom);
    for (int i = 0; i < m; i++) put_bits(fl >> (2 * (m - 1 - i)), 2);
    if (m > 0) put_bits($urandom, (8 - m) * 2);
    for (int i = 0; i < m; i++) begin
      if (fl[2 * (m - 1 - i) + 1]) begin
        put_bits({$urandom, $urandom}, 64);
        put_bits($urandom, 24);
      end
      if (fl[2 * (m - 1 - i)]) put_bits($urandom, 8);
    end
    put_ue(big ? 32'hfffffffe : $urandom_range(15));
    begin
      int c;
      c = big ? 3 : (mode == 2 ? 0 : $urandom_range(3));
      if (mode == 3 && $urandom_range(3) == 0) begin
        put_ue($urandom_range(4, 40));
        return;
      end
      put_ue(c);
      if (c == 3) put_bits($urandom_range(1), 1);
    end
    put_ue(big ? 32'hfffffffe : $urandom_range(4000));
    put_ue($urandom_range(4000));
    if (big || ($urandom_range(1) && mode != 2)) begin
      put_bits(1, 1);
      repeat (4) put_ue($urandom_range(20));
    end else put_bits(0, 1);
    if (mode == 3 && $urandom_range(2) == 0) begin
      put_ue($urandom_range(8, 300));
      return;
    end
    put_ue(big ? 7 : (mode == 2 ? 0 : $urandom_range(7)));
    if (mode == 3) begin
      if ($urandom_range(1)) put_ue($urandom_range(8, 300));
      else begin
        put_bits(0, 32 + $urandom_range(3));
        return;
      end
    end else put_ue(big ? 7 : (mode == 2 ? 0 : $urandom_range(7)));
  endtask

  task automatic noise_unit(int n);
    unit_bytes.delete();
    repeat (n)
      unit_bytes.insert(unit_bytes.size(),
                        $urandom_range(3) == 0 ? 8'h00 : 8'($urandom_range(255)));
  endtask

  // The sender stops offering bytes and waits for every expected result.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  initial begin
    int r;
    sb = new();
    cycles = 0;
    bytes_sent = 0;
    in_idle_pct = 14;
    out_idle_pct = 14;
    hold_results = 0;
    rst_n = 0;
    in_tvalid = 0;
    in_tdata = 0;
    in_tlast = 0;
    out_tready = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // Directed: short units, no payload, extremes, bad values, a truncation.
    unit_bytes = '{8'h40};
    send_unit();
    unit_bytes = '{8'h40, 8'h01};
    send_unit();
    unit_bytes = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h03, 8'h03, 8'hff};
    send_unit();
    build_sps(1); pack_unit(0); send_unit();
    build_sps(2); pack_unit(0); send_unit();
    repeat (3) begin
      build_sps(3); pack_unit(0); send_unit();
    end
    build_sps(0); pack_unit(4); send_unit();
    wait_drained();

    // Long receiver hold-off while the sender keeps offering bytes.
    fork
      begin
        hold_results = 1;
        repeat (3000) @(negedge clk);
        hold_results = 0;
      end
      begin
        repeat (6) begin
          build_sps(0); pack_unit(0); send_unit();
        end
        in_tvalid <= 1'b0;
        @(negedge clk);
      end
    join
    wait_drained();

    while (bytes_sent < 1950) begin
      r = $urandom_range(99);
      // A quiet stretch without idling on either side.
      if (bytes_sent > 900 && bytes_sent < 1300) begin
        in_idle_pct = 0; out_idle_pct = 0;
      end else begin
        in_idle_pct = 14; out_idle_pct = 14;
      end
      if (r < 65) begin
        build_sps(0); pack_unit(0);
      end else if (r < 78) begin
        build_sps(3); pack_unit(0);
      end else if (r < 88) begin
        build_sps(0); pack_unit($urandom_range(1, 20));
      end else noise_unit($urandom_range(1, 12));
      send_unit();
    end

    wait_drained();
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
